[rtl/lws_pkg.sv]
// Package with the request, status and width definitions of the LIFO stack.
package lws_pkg;

    localparam int WORD_W  = 32;
    localparam int FILL_W  = 8;

    typedef enum logic [1:0] {
        REQ_PUSH    = 2'd0,
        REQ_POP     = 2'd1,
        REQ_PEEK    = 2'd2,
        REQ_REVERSE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

[rtl/lws_if.sv]
// Request and response channel interfaces of the LIFO stack.
interface lws_req_if import lws_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic signed [WORD_W-1:0] push_value;

    modport source (output valid, req_type, push_value, input ready);
    modport sink   (input valid, req_type, push_value, output ready);
endinterface

interface lws_rsp_if import lws_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] top_value;
    logic [1:0]               status;
    logic                     is_empty;
    logic [FILL_W-1:0]        fill_count;

    modport source (output valid, top_value, status, is_empty, fill_count, input ready);
    modport sink   (input valid, top_value, status, is_empty, fill_count, output ready);
endinterface

[rtl/lws_ram.sv]
// Single-port-write, single-port-read synchronous memory holding the stack words.
module lws_ram import lws_pkg::*; #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lifo_stack_with_reverse.sv]
// Top level of the LIFO stack: circular-buffer pointers, direction flag and response register.
// Push, reverse and any failed request register their response directly; pop and peek
// first wait in S_READ for the registered read of the word memory.
// One push or reverse per cycle unless the response stalls; pop and peek stall in S_READ.
// Reverse only flips the direction flag, so it costs no memory traffic.
// Synchronous active-low reset empties the stack; memory contents are left as they are.
module lifo_stack_with_reverse import lws_pkg::*; #(
    parameter int DEPTH = 128
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lws_req_if.sink   i_req,
    lws_rsp_if.source o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                   r_state, n_state;
    logic [AW-1:0]            r_lo, n_lo;
    logic [AW-1:0]            r_hi, n_hi;
    logic                     r_dir, n_dir;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_rsp_valid, n_rsp_valid;
    logic signed [WORD_W-1:0] r_value, n_value;
    t_status                  r_status, n_status;
    logic                     r_empty, n_empty;
    logic [FILL_W-1:0]        r_fill, n_fill;

    logic              acc;
    logic              is_full;
    logic              is_emp;
    logic              we;
    logic              re;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     lo_dec;
    logic [AW-1:0]     lo_inc;
    logic [AW-1:0]     hi_dec;
    logic [AW-1:0]     hi_inc;
    logic [WORD_W-1:0] rdata;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
    endfunction

    assign acc     = i_req.valid && i_req.ready;
    assign is_full = (r_count == CW'(DEPTH));
    assign is_emp  = (r_count == '0);
    assign lo_dec  = ptr_dec(r_lo);
    assign lo_inc  = ptr_inc(r_lo);
    assign hi_dec  = ptr_dec(r_hi);
    assign hi_inc  = ptr_inc(r_hi);
    assign raddr   = r_dir ? r_lo : hi_dec;
    assign waddr   = r_dir ? lo_dec : r_hi;

    assign i_req.ready = (r_state == S_IDLE) && (!r_rsp_valid || o_rsp.ready);

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_dir       = r_dir;
        n_count     = r_count;
        n_rsp_valid = r_rsp_valid && !o_rsp.ready;
        n_value     = r_value;
        n_status    = r_status;
        n_empty     = r_empty;
        n_fill      = r_fill;
        we          = 1'b0;
        re          = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_value  = '0;
                    n_status = ST_DONE;
                    unique case (t_req'(i_req.req_type))
                        REQ_PUSH: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                n_count = r_count + CW'(1);
                                if (r_dir) begin
                                    n_lo = lo_dec;
                                end else begin
                                    n_hi = hi_inc;
                                end
                            end
                        end
                        REQ_POP: begin
                            if (is_emp) begin
                                n_status = ST_EMPTY;
                            end else begin
                                re      = 1'b1;
                                n_count = r_count - CW'(1);
                                if (r_dir) begin
                                    n_lo = lo_inc;
                                end else begin
                                    n_hi = hi_dec;
                                end
                            end
                        end
                        REQ_PEEK: begin
                            if (is_emp) begin
                                n_status = ST_EMPTY;
                            end else begin
                                re = 1'b1;
                            end
                        end
                        REQ_REVERSE: begin
                            if (is_emp) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_dir = !r_dir;
                            end
                        end
                    endcase
                    n_empty = (n_count == '0);
                    n_fill  = FILL_W'(n_count);
                    if (re) begin
                        n_state = S_READ;
                    end else begin
                        n_rsp_valid = 1'b1;
                    end
                end
            end
            S_READ: begin
                n_value     = rdata;
                n_rsp_valid = 1'b1;
                n_state     = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lo        <= '0;
            r_hi        <= '0;
            r_dir       <= 1'b0;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lo        <= n_lo;
            r_hi        <= n_hi;
            r_dir       <= n_dir;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
        r_value  <= n_value;
        r_status <= n_status;
        r_empty  <= n_empty;
        r_fill   <= n_fill;
    end

    lws_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_req.push_value),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.top_value  = r_value;
    assign o_rsp.status     = r_status;
    assign o_rsp.is_empty   = r_empty;
    assign o_rsp.fill_count = r_fill;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count exceeds the stack depth");

    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_rsp_valid)
        else $error("response register busy while a read is in flight");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_lo == r_hi))
        else $error("pointers differ on an empty stack");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_req.req_type == REQ_POP) && !is_emp)
            |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not remove exactly one entry");

endmodule

[test/tb.sv]
// Testbench of lifo_stack_with_reverse: directed and random requests checked against a stack model.
module tb;
    import lws_pkg::*;

    localparam int STACK_DEPTH = 128;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        logic signed [WORD_W-1:0] top_value;
        t_status                  status;
        logic                     is_empty;
        logic [FILL_W-1:0]        fill_count;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    lws_req_if req_ch ();
    lws_rsp_if rsp_ch ();

    lifo_stack_with_reverse #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    logic signed [WORD_W-1:0] model_words [STACK_DEPTH];
    int                       model_count = 0;
    t_outcome                 pending_outcomes [$];
    t_outcome                 oldest_outcome;
    int                       error_count = 0;
    int                       cycle_count = 0;
    int                       gap_pct = 0;
    int                       stall_pct = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lifo_stack_with_reverse regression: fail");
            $finish;
        end
    end

    function automatic t_outcome apply_request(input t_req kind,
                                               input logic signed [WORD_W-1:0] word);
        t_outcome                 res;
        logic signed [WORD_W-1:0] swap;
        int                       lo;
        int                       hi;
        res.top_value = '0;
        res.status    = ST_DONE;
        if (kind == REQ_PUSH) begin
            if (model_count >= STACK_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                model_words[model_count] = word;
                model_count++;
            end
        end else if (model_count == 0) begin
            res.status = ST_EMPTY;
        end else if (kind == REQ_POP) begin
            model_count--;
            res.top_value = model_words[model_count];
        end else if (kind == REQ_PEEK) begin
            res.top_value = model_words[model_count - 1];
        end else begin
            lo = 0;
            hi = model_count - 1;
            while (lo < hi) begin
                swap             = model_words[lo];
                model_words[lo]  = model_words[hi];
                model_words[hi]  = swap;
                lo++;
                hi--;
            end
        end
        res.is_empty   = (model_count == 0);
        res.fill_count = FILL_W'(model_count);
        return res;
    endfunction

    task automatic send_request(input t_req kind, input logic signed [WORD_W-1:0] word);
        @(negedge i_clk);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.push_value <= word;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_outcomes.push_back(apply_request(kind, word));
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        wait (pending_outcomes.size() == 0);
    endtask

    task automatic random_request(input int push_pct);
        t_req               kind;
        logic [WORD_W-1:0]  word;
        if ($urandom_range(0, 99) < push_pct) begin
            kind = REQ_PUSH;
        end else begin
            case ($urandom_range(0, 5))
                0, 1, 2: kind = REQ_POP;
                3, 4:    kind = REQ_PEEK;
                default: kind = REQ_REVERSE;
            endcase
        end
        case ($urandom_range(0, 9))
            0:       word = 32'h8000_0000;
            1:       word = 32'h7FFF_FFFF;
            2:       word = '0;
            3:       word = '1;
            default: word = $urandom;
        endcase
        send_request(kind, word);
    endtask

    // Pop, peek and reverse on an empty stack fail, and a single entry survives a reverse.
    task automatic test_empty_stack();
        send_request(REQ_POP, $urandom);
        send_request(REQ_PEEK, $urandom);
        send_request(REQ_REVERSE, $urandom);
        send_request(REQ_PUSH, 32'sd100);
        send_request(REQ_REVERSE, $urandom);
        send_request(REQ_PEEK, $urandom);
        send_request(REQ_POP, $urandom);
        send_request(REQ_POP, $urandom);
    endtask

    task automatic test_word_extremes();
        send_request(REQ_PUSH, 32'h8000_0000);
        send_request(REQ_PUSH, 32'h7FFF_FFFF);
        send_request(REQ_PUSH, '0);
        send_request(REQ_PUSH, '1);
        send_request(REQ_REVERSE, $urandom);
        send_request(REQ_PUSH, 32'sd1);
        send_request(REQ_REVERSE, $urandom);
        send_request(REQ_PEEK, $urandom);
        repeat (6) send_request(REQ_POP, $urandom);
    endtask

    task automatic test_full_stack();
        while (model_count < STACK_DEPTH) send_request(REQ_PUSH, $urandom);
        repeat (2) send_request(REQ_PUSH, $urandom);
        send_request(REQ_REVERSE, $urandom);
        send_request(REQ_PEEK, $urandom);
        repeat (5) send_request(REQ_POP, $urandom);
        while (model_count < STACK_DEPTH) send_request(REQ_PUSH, $urandom);
        send_request(REQ_PUSH, $urandom);
        send_request(REQ_REVERSE, $urandom);
        wait_for_results();
        while (model_count > 0) begin
            if ($urandom_range(0, 7) == 0) begin
                send_request(REQ_PEEK, $urandom);
            end else begin
                send_request(REQ_POP, $urandom);
            end
        end
        send_request(REQ_POP, $urandom);
    endtask

    task automatic test_random_mix();
        int push_pct;
        for (int phase = 0; phase < 8; phase++) begin
            push_pct  = $urandom_range(25, 85);
            gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
            repeat (50) random_request(push_pct);
            if (phase % 3 == 2) begin
                wait_for_results();
            end
        end
    endtask

    task automatic test_back_to_back();
        gap_pct   = 0;
        stall_pct = 0;
        repeat (80) random_request(50);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_outcomes.size() == 0) begin
                $error("response with no request outstanding");
                error_count++;
            end else begin
                oldest_outcome = pending_outcomes.pop_front();
                if (rsp_ch.top_value !== oldest_outcome.top_value) begin
                    $error("top_value: expected %0d, got %0d",
                           oldest_outcome.top_value, rsp_ch.top_value);
                    error_count++;
                end
                if (rsp_ch.status !== oldest_outcome.status) begin
                    $error("status: expected %0d, got %0d",
                           oldest_outcome.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.is_empty !== oldest_outcome.is_empty) begin
                    $error("is_empty: expected %0d, got %0d",
                           oldest_outcome.is_empty, rsp_ch.is_empty);
                    error_count++;
                end
                if (rsp_ch.fill_count !== oldest_outcome.fill_count) begin
                    $error("fill_count: expected %0d, got %0d",
                           oldest_outcome.fill_count, rsp_ch.fill_count);
                    error_count++;
                end
            end
        end
    end

    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_PUSH;
        req_ch.push_value = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct   = 20;
        stall_pct = 20;
        test_empty_stack();
        test_word_extremes();
        test_full_stack();
        test_random_mix();
        test_back_to_back();

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("lifo_stack_with_reverse regression: pass");
        end else begin
            $display("lifo_stack_with_reverse regression: fail");
        end
        $finish;
    end

endmodule
